### rtl/swtq_pkg.sv
`default_nettype none

package swtq_pkg;

    // Default number of entries in the sorted wake queue.
    localparam int QUEUE_DEPTH_DEFAULT = 16;

    // Entries in the command queue between the front and the back.
    localparam int CMD_QUEUE_DEPTH = 2;

    // Request type codes.
    localparam logic REQ_SLEEP = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Result kind codes.
    localparam logic RES_WOKEN    = 1'b0;
    localparam logic RES_REJECTED = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  thread_in;
        logic [31:0] sleep_seconds;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] thread_out;
        logic       last_of_run;
    } t_out_item;

    // Classified command as handed from the front to the back.
    typedef struct packed {
        logic        is_tick;
        logic [7:0]  task_id;
        logic [31:0] duration;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/swtq_front.sv
`default_nettype none

module swtq_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  swtq_pkg::t_in_item i_in_item,
    output logic              o_cmd_valid,
    input  wire               i_cmd_stall,
    output swtq_pkg::t_cmd    o_cmd
);

    localparam int Depth = swtq_pkg::CMD_QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int FillW = $clog2(Depth + 1);

    swtq_pkg::t_cmd    r_mem [Depth];
    logic [PtrW-1:0]   r_wr, n_wr;
    logic [PtrW-1:0]   r_rd, n_rd;
    logic [FillW-1:0]  r_fill, n_fill;
    logic              push, pop;
    swtq_pkg::t_cmd    cls;

    // Classify the incoming transaction into a command.
    always_comb begin
        cls.is_tick  = (i_in_item.req_type == swtq_pkg::REQ_TICK);
        cls.task_id  = i_in_item.thread_in;
        cls.duration = i_in_item.sleep_seconds;
    end

    assign o_in_stall  = (r_fill == FillW'(Depth));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_mem[r_rd];

    assign push = i_in_valid && !o_in_stall;
    assign pop  = o_cmd_valid && !i_cmd_stall;

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + PtrW'(1);
        end
        if (pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + PtrW'(1);
        end
        if (push && !pop) begin
            n_fill = r_fill + FillW'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - FillW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

endmodule

`default_nettype wire

### rtl/swtq_back.sv
`default_nettype none

module swtq_back #(
    parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cmd_valid,
    output logic                o_cmd_stall,
    input  swtq_pkg::t_cmd      i_cmd,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output swtq_pkg::t_out_item o_out_item
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic                r_state, n_state;
    logic [31:0]         r_time, n_time;
    logic [CW-1:0]       r_count, n_count;
    logic [31:0]         r_wake [QUEUE_DEPTH];
    logic [31:0]         n_wake [QUEUE_DEPTH];
    logic [7:0]          r_tid [QUEUE_DEPTH];
    logic [7:0]          n_tid [QUEUE_DEPTH];
    logic                r_out_valid, n_out_valid;
    swtq_pkg::t_out_item r_out_item, n_out_item;

    logic                   out_free;
    logic                   cmd_take;
    logic                   full;
    logic                   head_due;
    logic                   next_due;
    logic [31:0]            wake;
    logic [QUEUE_DEPTH-1:0] at_or_after;
    logic                   do_insert;
    logic                   do_pop;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cmd_stall = !((r_state == ST_IDLE) && out_free);
    assign cmd_take    = i_cmd_valid && !o_cmd_stall;
    assign full        = (r_count == CW'(QUEUE_DEPTH));
    assign head_due    = (r_count != '0) && (r_wake[0] <= r_time);
    assign next_due    = (r_count >= CW'(2)) && (r_wake[1] <= r_time);
    assign wake        = r_time + i_cmd.duration;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The new entry goes in front of the first entry that wakes strictly later,
    // so equal wake times keep arrival order.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            at_or_after[i] = (CW'(i) >= r_count) || (r_wake[i] > wake);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        do_insert   = 1'b0;
        do_pop      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_take) begin
                    if (i_cmd.is_tick) begin
                        n_state = ST_POP;
                    end else if (full) begin
                        n_out_valid            = 1'b1;
                        n_out_item.result_kind = swtq_pkg::RES_REJECTED;
                        n_out_item.thread_out  = i_cmd.task_id;
                        n_out_item.last_of_run = 1'b1;
                    end else begin
                        do_insert = 1'b1;
                        n_count   = r_count + CW'(1);
                    end
                end
            end
            ST_POP: begin
                if (!head_due) begin
                    n_time  = r_time + 32'd1;
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    do_pop                 = 1'b1;
                    n_count                = r_count - CW'(1);
                    n_out_valid            = 1'b1;
                    n_out_item.result_kind = swtq_pkg::RES_WOKEN;
                    n_out_item.thread_out  = r_tid[0];
                    n_out_item.last_of_run = !next_due;
                    if (!next_due) begin
                        n_time  = r_time + 32'd1;
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_comb begin
        n_wake = r_wake;
        n_tid  = r_tid;
        if (do_insert) begin
            if (at_or_after[0]) begin
                n_wake[0] = wake;
                n_tid[0]  = i_cmd.task_id;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (at_or_after[i]) begin
                    n_wake[i] = at_or_after[i-1] ? r_wake[i-1] : wake;
                    n_tid[i]  = at_or_after[i-1] ? r_tid[i-1] : i_cmd.task_id;
                end
            end
        end else if (do_pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_wake[i] = r_wake[i+1];
                n_tid[i]  = r_tid[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wake     <= n_wake;
        r_tid      <= n_tid;
        r_out_item <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_time      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/sorted_wake_timer_queue.sv
`default_nettype none
// Sorted wake-time queue for sleeping tasks.
// The input channel carries one request per transaction: a sleep request
// (task id and duration) or a single time tick. The output channel carries
// one result per transaction: a woken task id, or a rejected sleep request
// when the queue is full. last_of_run marks the final result of a request.
// Accepted requests land in a two-entry command queue, so the input keeps
// flowing while the back end works or the receiver stalls.
// A sleep request is inserted once it reaches the back end, by a parallel
// compare of its wake time against every entry and a shift of the entry
// registers; a run of sleep requests sustains one per cycle unless the
// receiver stalls. A tick moves the back end into its pop state, then
// pops one due entry per cycle from the head of the queue while the output
// is free; once none is due, the time advances and the back end idles.
// A result appears on the output in the cycle after the back end makes it.
// When the receiver holds stall, the output register keeps its transaction
// and the back end pauses; once the command queue fills, the input stalls.
// Reset clears the time, the entry count and all valid flags; the entry
// registers need no clearing pass and the block is ready at once.

module sorted_wake_timer_queue #(
    parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  swtq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output swtq_pkg::t_out_item o_out_item
);

    // Command transactions from the front end to the back end.
    logic           cmd_valid;
    logic           cmd_stall;
    swtq_pkg::t_cmd cmd;

    // The front end classifies each request and buffers it.
    swtq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_stall (cmd_stall),
        .o_cmd       (cmd)
    );

    // The back end owns the time, the sorted entries and the output register.
    swtq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_stall (cmd_stall),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

### rtl/swtq_checker.sv
`default_nettype none

module swtq_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input swtq_pkg::t_in_item  i_in_item,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input swtq_pkg::t_out_item o_out_item
);

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Reset empties the command queue, so the input is open.
    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // A stalled request is held by the sender.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled request changed");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // A rejection is always the only result of its request.
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.result_kind == swtq_pkg::RES_REJECTED)
        |-> o_out_item.last_of_run)
        else $error("rejection without last_of_run");

endmodule

bind sorted_wake_timer_queue swtq_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
